### rtl/sfr_pkg.sv
package sfr_pkg;

   localparam int BYTE_W = 8;
   localparam int LEN_W  = 4;
   localparam int CFG_W  = 64;
   localparam int IDX_W  = 3;

   // Configuration register indexes.
   localparam logic [IDX_W-1:0] CSR_PATTERN_BYTES      = 3'd0;
   localparam logic [IDX_W-1:0] CSR_PATTERN_LENGTH     = 3'd1;
   localparam logic [IDX_W-1:0] CSR_REPLACEMENT_BYTES  = 3'd2;
   localparam logic [IDX_W-1:0] CSR_REPLACEMENT_LENGTH = 3'd3;

   // Sequencer to output stage.
   typedef struct packed {
      logic              push;
      logic              close;
      logic [BYTE_W-1:0] data;
   } out_cmd_type;

   // Output stage to sequencer.
   typedef struct packed {
      logic can_push;
   } out_stat_type;

endpackage

### rtl/stream_find_replace_unit.sv
// Channel   Direction  Handshake              Payload
// req_      in         req_valid / req_stall  req_in_byte, req_end_of_stream
// rsp_      out        rsp_valid / rsp_stall  rsp_out_byte, rsp_last_of_run
// csr_      in         csr_write_enable       csr_index, csr_write_data
//
// Each beat is taken in ST_IDLE and judged in ST_CHECK, which releases
// window head bytes; a match goes on to ST_REPL and ST_FLUSH, end of stream
// to ST_FLUSH. The sequencer emits at most one byte per cycle into the output
// stage, reuses one prefix comparator for every window decision and is held
// by a stall on rsp_. Synchronous reset clears CSRs, state, EOS, window count.
module stream_find_replace_unit #(
   parameter int MAX_PATTERN     = 8,
   parameter int MAX_REPLACEMENT = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [sfr_pkg::BYTE_W-1:0]  req_in_byte,
   input  logic                        req_end_of_stream,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sfr_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last_of_run,
   input  logic                        csr_write_enable,
   input  logic [sfr_pkg::IDX_W-1:0]   csr_index,
   input  logic [sfr_pkg::CFG_W-1:0]   csr_write_data
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_REPL,
      ST_FLUSH
   } state_type;

   localparam int BW = sfr_pkg::BYTE_W;
   localparam int LW = sfr_pkg::LEN_W;

   logic [sfr_pkg::CFG_W-1:0] pattern_ff;
   logic [LW-1:0]             plen_ff;
   logic [sfr_pkg::CFG_W-1:0] repl_ff;
   logic [LW-1:0]             rlen_ff;

   state_type                       state_ff, state_in;
   logic [MAX_PATTERN-1:0][BW-1:0]  window_ff, window_in;
   logic [LW-1:0]                   count_ff, count_in;
   logic                            eos_ff, eos_in;
   logic [sfr_pkg::CFG_W-1:0]       rep_shift_ff, rep_shift_in;
   logic [LW-1:0]                   rep_left_ff, rep_left_in;

   logic [LW-1:0]         plen_eff;
   logic [LW-1:0]         rlen_eff;
   logic                  match;
   sfr_pkg::out_cmd_type  cmd;
   sfr_pkg::out_stat_type stat;

   assign plen_eff = (plen_ff > LW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : plen_ff;
   assign rlen_eff = (rlen_ff > LW'(MAX_REPLACEMENT)) ? LW'(MAX_REPLACEMENT) : rlen_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         plen_ff    <= '0;
         repl_ff    <= '0;
         rlen_ff    <= '0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            sfr_pkg::CSR_PATTERN_BYTES:      pattern_ff <= csr_write_data;
            sfr_pkg::CSR_PATTERN_LENGTH:     plen_ff    <= csr_write_data[LW-1:0];
            sfr_pkg::CSR_REPLACEMENT_BYTES:  repl_ff    <= csr_write_data;
            sfr_pkg::CSR_REPLACEMENT_LENGTH: rlen_ff    <= csr_write_data[LW-1:0];
            default: ;
         endcase
      end
   end

   sfr_prefix_cmp #(
      .DEPTH(MAX_PATTERN)
   ) u_cmp (
      .window (window_ff),
      .pattern(pattern_ff),
      .length (count_ff),
      .match  (match)
   );

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in     = state_ff;
      window_in    = window_ff;
      count_in     = count_ff;
      eos_in       = eos_ff;
      rep_shift_in = rep_shift_ff;
      rep_left_in  = rep_left_ff;
      cmd.push     = 1'b0;
      cmd.close    = 1'b0;
      cmd.data     = window_ff[0];
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               for (int i = 0; i < MAX_PATTERN; i++) begin
                  if (count_ff == LW'(i)) begin
                     window_in[i] = req_in_byte;
                  end
               end
               count_in = count_ff + LW'(1);
               eos_in   = req_end_of_stream;
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            priority if ((count_ff != '0) && (count_ff == plen_eff) && match) begin
               // Full match: the window is replaced and emptied.
               rep_shift_in = repl_ff;
               rep_left_in  = rlen_eff;
               count_in     = '0;
               state_in     = (rlen_eff != '0) ? ST_REPL : ST_FLUSH;
            end else if ((count_ff == '0) || ((count_ff < plen_eff) && match)) begin
               if (eos_ff && (count_ff != '0)) begin
                  state_in = ST_FLUSH;
               end else if (stat.can_push) begin
                  cmd.close = 1'b1;
                  state_in  = ST_IDLE;
               end
            end else begin
               // Window is no longer a pattern prefix: release its head.
               if (stat.can_push) begin
                  cmd.push  = 1'b1;
                  window_in = window_ff >> BW;
                  count_in  = count_ff - LW'(1);
               end
            end
         end
         ST_REPL: begin
            if (stat.can_push) begin
               cmd.push     = 1'b1;
               cmd.data     = rep_shift_ff[BW-1:0];
               rep_shift_in = rep_shift_ff >> BW;
               rep_left_in  = rep_left_ff - LW'(1);
               if (rep_left_ff == LW'(1)) begin
                  state_in = ST_FLUSH;
               end
            end
         end
         ST_FLUSH: begin
            if (stat.can_push) begin
               if (eos_ff && (count_ff != '0)) begin
                  cmd.push  = 1'b1;
                  window_in = window_ff >> BW;
                  count_in  = count_ff - LW'(1);
               end else begin
                  cmd.close = 1'b1;
                  state_in  = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         eos_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         eos_ff   <= eos_in;
      end
      window_ff    <= window_in;
      rep_shift_ff <= rep_shift_in;
      rep_left_ff  <= rep_left_in;
   end

   sfr_out_stage u_out (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

### rtl/sfr_prefix_cmp.sv
module sfr_prefix_cmp #(
   parameter int DEPTH = 8
) (
   input  logic [DEPTH-1:0][sfr_pkg::BYTE_W-1:0] window,
   input  logic [sfr_pkg::CFG_W-1:0]             pattern,
   input  logic [sfr_pkg::LEN_W-1:0]             length,
   output logic                                  match
);

   // The first length bytes of the window must equal the pattern prefix.
   always_comb begin
      match = 1'b1;
      for (int i = 0; i < DEPTH; i++) begin
         if ((sfr_pkg::LEN_W'(i) < length) &&
             (window[i] != pattern[i*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W])) begin
            match = 1'b0;
         end
      end
   end

endmodule

### rtl/sfr_out_stage.sv
module sfr_out_stage (
   input  logic                        clock,
   input  logic                        reset,
   input  sfr_pkg::out_cmd_type        cmd,
   output sfr_pkg::out_stat_type       stat,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [sfr_pkg::BYTE_W-1:0]  rsp_out_byte,
   output logic                        rsp_last_of_run
);

   logic                       pend_valid_ff, pend_valid_in;
   logic [sfr_pkg::BYTE_W-1:0] pend_byte_ff, pend_byte_in;
   logic                       out_valid_ff, out_valid_in;
   logic [sfr_pkg::BYTE_W-1:0] out_byte_ff, out_byte_in;
   logic                       out_last_ff, out_last_in;
   logic                       out_free;

   // One byte is kept back so that the final byte of a run can be flagged
   // once the sequencer knows no more bytes follow.
   assign out_free      = !out_valid_ff || !rsp_stall;
   assign stat.can_push = !pend_valid_ff || out_free;

   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_byte_in  = pend_byte_ff;
      out_valid_in  = out_valid_ff && rsp_stall;
      out_byte_in   = out_byte_ff;
      out_last_in   = out_last_ff;
      if (cmd.push) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_byte_in  = pend_byte_ff;
            out_last_in  = 1'b0;
         end
         pend_valid_in = 1'b1;
         pend_byte_in  = cmd.data;
      end else if (cmd.close && pend_valid_ff) begin
         out_valid_in  = 1'b1;
         out_byte_in   = pend_byte_ff;
         out_last_in   = 1'b1;
         pend_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
      pend_byte_ff <= pend_byte_in;
      out_byte_ff  <= out_byte_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_last_of_run = out_last_ff;

endmodule
